### src/ofsl_pkg.sv
// Package for the object file section loader: parse phase and section kind
// types, header word codes and the result item struct.
// No dependencies.
package ofsl_pkg;

  localparam int unsigned WordBits = 16;
  localparam int unsigned ByteBits = 8;

  // Header words
  localparam logic [WordBits-1:0] HdrCode = 16'hCADE;
  localparam logic [WordBits-1:0] HdrData = 16'hDADA;
  localparam logic [WordBits-1:0] HdrSym  = 16'hC3B7;
  localparam logic [WordBits-1:0] HdrName = 16'hF17E;
  localparam logic [WordBits-1:0] HdrLine = 16'h715E;

  // Bytes skipped after a line-number header
  localparam logic [WordBits-1:0] LineSkipBytes = 16'd6;

  typedef enum logic [8:0] {
    PH_HDR_HI  = 9'b0_0000_0001,
    PH_HDR_LO  = 9'b0_0000_0010,
    PH_ADDR_HI = 9'b0_0000_0100,
    PH_ADDR_LO = 9'b0_0000_1000,
    PH_CNT_HI  = 9'b0_0001_0000,
    PH_CNT_LO  = 9'b0_0010_0000,
    PH_DATA_HI = 9'b0_0100_0000,
    PH_DATA_LO = 9'b0_1000_0000,
    PH_SKIP    = 9'b1_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CODE = 2'd0,
    KIND_SYM  = 2'd1,
    KIND_NAME = 2'd2,
    KIND_LINE = 2'd3
  } kind_e;

  typedef enum logic {
    EV_WRITE   = 1'b0,
    EV_UNKNOWN = 1'b1
  } event_e;

  typedef struct packed {
    logic                event_kind;
    logic [WordBits-1:0] write_address;
    logic [WordBits-1:0] word_value;
  } result_t;

endpackage

### src/ofsl_parser.sv
// Section parser: phase state machine, byte latch, address and count
// registers, and the result each byte produces. Depends on ofsl_pkg.
module ofsl_parser
  import ofsl_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [ByteBits-1:0] file_byte_i,
  input  logic                new_file_i,
  output logic                res_valid_o,
  output result_t             res_o
);

  phase_e                  phase_q, phase_d, phase_eff;
  logic [ByteBits-1:0]     hi_q, hi_d;
  kind_e                   kind_q, kind_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  logic [WordBits-1:0]     cnt_q, cnt_d;
  logic [WordBits-1:0]     word;
  logic [WordBits-1:0]     cnt_dec;

  assign word      = {hi_q, file_byte_i};
  assign cnt_dec   = cnt_q - 16'd1;
  assign phase_eff = new_file_i ? PH_HDR_HI : phase_q;

  always_comb begin
    phase_d     = phase_q;
    hi_d        = hi_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_eff)
      PH_HDR_LO: begin
        if (word == HdrCode || word == HdrData) begin
          kind_d  = KIND_CODE;
          phase_d = PH_ADDR_HI;
        end else if (word == HdrSym) begin
          kind_d  = KIND_SYM;
          phase_d = PH_ADDR_HI;
        end else if (word == HdrName) begin
          kind_d  = KIND_NAME;
          phase_d = PH_CNT_HI;
        end else if (word == HdrLine) begin
          kind_d  = KIND_LINE;
          cnt_d   = LineSkipBytes;
          phase_d = PH_SKIP;
        end else begin
          res_valid_o         = 1'b1;
          res_o.event_kind    = EV_UNKNOWN;
          res_o.write_address = '0;
          res_o.word_value    = word;
          phase_d             = PH_HDR_HI;
        end
      end
      PH_ADDR_LO: begin
        addr_d  = word[ADDRESS_BITS-1:0];
        phase_d = PH_CNT_HI;
      end
      PH_CNT_LO: begin
        cnt_d = word;
        if (word == '0) begin
          phase_d = PH_HDR_HI;
        end else if (kind_q == KIND_CODE) begin
          phase_d = PH_DATA_HI;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_DATA_LO: begin
        res_valid_o         = 1'b1;
        res_o.event_kind    = EV_WRITE;
        res_o.write_address = WordBits'(addr_q);
        res_o.word_value    = word;
        addr_d              = addr_q + 1'b1;
        cnt_d               = cnt_dec;
        phase_d             = (cnt_dec == '0) ? PH_HDR_HI : PH_DATA_HI;
      end
      PH_SKIP: begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          phase_d = PH_HDR_HI;
        end
      end
      PH_ADDR_HI: begin
        hi_d    = file_byte_i;
        phase_d = PH_ADDR_LO;
      end
      PH_CNT_HI: begin
        hi_d    = file_byte_i;
        phase_d = PH_CNT_LO;
      end
      PH_DATA_HI: begin
        hi_d    = file_byte_i;
        phase_d = PH_DATA_LO;
      end
      default: begin
        // header high byte, and any corrupt phase code
        hi_d    = file_byte_i;
        phase_d = PH_HDR_LO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR_HI;
      hi_q    <= '0;
      kind_q  <= KIND_CODE;
      addr_q  <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hi_q    <= hi_d;
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### src/ofsl_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on ofsl_pkg for the result struct.
module ofsl_out_reg
  import ofsl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  logic    load_valid_i,
  input  result_t load_data_i,
  input  logic    out_ready_i,
  output logic    free_o,
  output logic    out_valid_o,
  output result_t out_data_o
);

  logic    valid_q;
  result_t data_q;

  // register may take a new value when empty or being drained this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= load_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_valid_i) begin
      data_q <= load_data_i;
    end
  end

endmodule

### src/object_file_section_loader.sv
// Top level of the object file section loader: input register, section
// parser and result register. Depends on ofsl_pkg, ofsl_parser, ofsl_out_reg.
//
// The loader takes an object file one byte per item (big-endian words) and
// turns code and data sections (headers 0xCADE / 0xDADA) into memory write
// items, one per payload word, at consecutive addresses that wrap within
// ADDRESS_BITS bits. Symbol, file-name and line-number sections are parsed
// and their bodies skipped. Any other header word yields one item with
// event_kind = 1, the word in word_value and write_address = 0. Setting
// new_file_i on a byte restarts the parser with that byte as a header high
// byte. Rate: one byte per cycle sustained. Each byte is held in the input
// register until the result register is free; the parser then consumes
// it, updates its phase and loads the result register, which presents the
// result to the consumer. A stalled consumer holds the result register,
// which then back-pressures the input register; nothing else limits
// throughput.
module object_file_section_loader
  import ofsl_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteBits-1:0] file_byte_i,
  input  logic                new_file_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                event_kind_o,
  output logic [WordBits-1:0] write_address_o,
  output logic [WordBits-1:0] word_value_o
);

  // input register
  logic                in_valid_q;
  logic [ByteBits-1:0] byte_q;
  logic                new_file_q;

  logic    advance;   // result register can take whatever the parser yields
  logic    step;      // parser consumes the registered byte
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign step       = advance && in_valid_q;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q     <= file_byte_i;
      new_file_q <= new_file_i;
    end
  end

  ofsl_parser #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .file_byte_i(byte_q),
    .new_file_i (new_file_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // bytes that produce nothing still load the register, leaving it empty
  ofsl_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .load_valid_i(res_valid),
    .load_data_i (res),
    .out_ready_i (out_ready_i),
    .free_o      (advance),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data)
  );

  assign event_kind_o    = out_data.event_kind;
  assign write_address_o = out_data.write_address;
  assign word_value_o    = out_data.word_value;

endmodule

### src/ofsl_checker.sv
// Port-level checks for the object file section loader, bound to the top.
// Depends on ofsl_pkg and object_file_section_loader.
module ofsl_checker
  import ofsl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [ByteBits-1:0] file_byte_i,
  input logic                new_file_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                event_kind_o,
  input logic [WordBits-1:0] write_address_o,
  input logic [WordBits-1:0] word_value_o
);

  // offered input item holds while it waits
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(file_byte_i)
      && $stable(new_file_i))
    else $error("waiting input item changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(write_address_o) && $stable(word_value_o))
    else $error("stalled result item changed");

  // unrecognized header reports address zero
  a_unknown_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_UNKNOWN |-> write_address_o == '0)
    else $error("unrecognized item with nonzero address");

  // an empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a new result follows an accepted item via the input and result registers
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result item without a matching input item");

endmodule

bind object_file_section_loader ofsl_checker u_ofsl_checker (.*);

### bench/tb_top.sv
// Testbench for object_file_section_loader: drives object files byte by byte
// and checks the write and unrecognized-header items against its own parser.
// Depends on ofsl_pkg and object_file_section_loader.
`timescale 1ns / 100ps

module tb_top
  import ofsl_pkg::*;
;

  localparam int unsigned AddrBits = 16;
  localparam logic [WordBits-1:0] AddrMask = WordBits'((32'h1 << AddrBits) - 1);
  localparam int unsigned RandItems = 600;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted = 100;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ByteBits-1:0] file_byte_i = '0;
  logic                new_file_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                event_kind_o;
  logic [WordBits-1:0] write_address_o;
  logic [WordBits-1:0] word_value_o;

  // Stimulus control shared between the sender, the receiver and the main flow
  logic        start_of_file = 1'b0;
  logic        steady = 1'b0;
  logic        hold_off_req = 1'b0;
  int unsigned bytes_taken = 0;

  // Section parser mirror plus the queue of items still due from the block.
  class section_scoreboard;
    phase_e      phase;
    kind_e       kind;
    logic [ByteBits-1:0] hi_byte;
    logic [WordBits-1:0] next_addr;
    logic [WordBits-1:0] left_count;
    result_t     due_events[$];
    int unsigned errors;

    function new();
      phase      = PH_HDR_HI;
      kind       = KIND_CODE;
      hi_byte    = '0;
      next_addr  = '0;
      left_count = '0;
      errors     = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function int unsigned pending();
      return due_events.size();
    endfunction

    // Advance the parser by one accepted byte, queueing any item it causes.
    task take_byte(input logic [ByteBits-1:0] b, input logic nf);
      logic [WordBits-1:0] word;
      result_t ev;
      if (nf) phase = PH_HDR_HI;
      word = {hi_byte, b};
      ev = '0;
      case (phase)
        PH_HDR_LO: begin
          if (word == HdrCode || word == HdrData) begin
            kind  = KIND_CODE;
            phase = PH_ADDR_HI;
          end else if (word == HdrSym) begin
            kind  = KIND_SYM;
            phase = PH_ADDR_HI;
          end else if (word == HdrName) begin
            kind  = KIND_NAME;
            phase = PH_CNT_HI;
          end else if (word == HdrLine) begin
            kind       = KIND_LINE;
            left_count = LineSkipBytes;
            phase      = PH_SKIP;
          end else begin
            // unrecognized header: address field reads zero
            ev.event_kind    = EV_UNKNOWN;
            ev.write_address = '0;
            ev.word_value    = word;
            due_events.push_back(ev);
            phase = PH_HDR_HI;
          end
        end
        PH_ADDR_HI: begin
          hi_byte = b;
          phase   = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          next_addr = word;
          phase     = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          hi_byte = b;
          phase   = PH_CNT_LO;
        end
        PH_CNT_LO: begin
          left_count = word;
          if (left_count == '0) phase = PH_HDR_HI;
          else if (kind == KIND_CODE) phase = PH_DATA_HI;
          else phase = PH_SKIP;
        end
        PH_DATA_HI: begin
          hi_byte = b;
          phase   = PH_DATA_LO;
        end
        PH_DATA_LO: begin
          ev.event_kind    = EV_WRITE;
          ev.write_address = next_addr & AddrMask;
          ev.word_value    = word;
          due_events.push_back(ev);
          next_addr  = (next_addr + 1'b1) & AddrMask;
          left_count = left_count - 1'b1;
          phase      = (left_count == '0) ? PH_HDR_HI : PH_DATA_HI;
        end
        PH_SKIP: begin
          left_count = left_count - 1'b1;
          if (left_count == '0) phase = PH_HDR_HI;
        end
        default: begin
          hi_byte = b;
          phase   = PH_HDR_LO;
        end
      endcase
    endtask

    task check_result(input result_t got);
      result_t want;
      if (due_events.size() == 0) begin
        report($sformatf("unexpected item kind=%0d addr=%h value=%h",
                         got.event_kind, got.write_address, got.word_value));
        return;
      end
      want = due_events.pop_front();
      if (got.event_kind !== want.event_kind)
        report($sformatf("event_kind got %0d want %0d", got.event_kind, want.event_kind));
      if (got.write_address !== want.write_address)
        report($sformatf("write_address got %h want %h",
                         got.write_address, want.write_address));
      if (got.word_value !== want.word_value)
        report($sformatf("word_value got %h want %h", got.word_value, want.word_value));
    endtask

    task check_drained();
      if (due_events.size() != 0)
        report($sformatf("%0d items never arrived", due_events.size()));
    endtask
  endclass

  section_scoreboard board = new();

  object_file_section_loader #(
    .ADDRESS_BITS(AddrBits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .file_byte_i    (file_byte_i),
    .new_file_i     (new_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .write_address_o(write_address_o),
    .word_value_o   (word_value_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Both handshakes are observed at the rising edge, before any flop update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        board.take_byte(file_byte_i, new_file_i);
        bytes_taken++;
      end
      if (out_valid_o && out_ready_i)
        board.check_result('{event_kind: event_kind_o, write_address: write_address_o,
                             word_value: word_value_o});
    end
  end

  // Mostly short gaps, now and then a long one; none while steady is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Addresses cluster near the top now and then so the wrap gets exercised.
  function automatic logic [WordBits-1:0] pick_addr();
    if ($urandom_range(0, 3) == 0) return WordBits'($urandom_range(16'hFFF8, 16'hFFFF));
    return WordBits'($urandom_range(0, 16'hFFFF));
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Offer one byte after a random gap and hold it until taken. The first byte
  // of a file carries the new-file flag.
  task automatic put_byte(input logic [ByteBits-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    file_byte_i <= b;
    new_file_i  <= start_of_file;
    start_of_file = 1'b0;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic put_word(input logic [WordBits-1:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic put_code(input logic [WordBits-1:0] hdr, input logic [WordBits-1:0] addr,
                          input logic [WordBits-1:0] n_words);
    put_word(hdr);
    put_word(addr);
    put_word(n_words);
    repeat (n_words) put_word(WordBits'($urandom_range(0, 16'hFFFF)));
  endtask

  // One file: a few sections of mixed kinds, mostly well formed. A truncated
  // section always ends the file so the next file's flag restarts the parser.
  task automatic send_file();
    int unsigned n_sections;
    int unsigned r;
    logic [WordBits-1:0] n;
    start_of_file = 1'b1;
    n_sections = $urandom_range(1, 4);
    repeat (n_sections) begin
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? '0 : WordBits'($urandom_range(1, 6));
      if (r < 45) begin
        put_code(r[0] ? HdrCode : HdrData, pick_addr(), n);
      end else if (r < 57) begin
        put_word(HdrSym);
        put_word(pick_addr());
        put_word(n);
        repeat (n) put_byte(ByteBits'($urandom_range(0, 255)));
      end else if (r < 69) begin
        put_word(HdrName);
        put_word(n);
        repeat (n) put_byte(ByteBits'($urandom_range(0, 255)));
      end else if (r < 79) begin
        put_word(HdrLine);
        repeat (LineSkipBytes) put_byte(ByteBits'($urandom_range(0, 255)));
      end else if (r < 89) begin
        // most random words are not headers
        put_word(WordBits'($urandom_range(0, 16'hFFFF)));
      end else if (r < 95) begin
        // usually truncated section, sometimes with the largest count
        put_word(r[0] ? HdrCode : HdrSym);
        put_word(pick_addr());
        put_word($urandom_range(0, 1) ? 16'hFFFF : n + 16'd2);
        repeat ($urandom_range(0, 5)) put_byte(ByteBits'($urandom_range(0, 255)));
        return;
      end else begin
        // loose bytes, some of them restarting the parser
        repeat ($urandom_range(1, 4)) begin
          start_of_file = ($urandom_range(0, 3) == 0);
          put_byte(ByteBits'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    logic held;
    logic drained_once;
    held = 1'b0;
    drained_once = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: wrapping code section with extreme words, unrecognized zero
    // word, line-number skip, empty file-name section, unrecognized all-ones.
    start_of_file = 1'b1;
    put_word(HdrCode);
    put_word(16'hFFFF);
    put_word(16'd2);
    put_word(16'h0000);
    put_word(16'hFFFF);
    put_word(16'h0000);
    put_word(HdrLine);
    repeat (LineSkipBytes) put_byte(8'hFF);
    put_word(HdrName);
    put_word(16'h0000);
    put_word(16'hFFFF);

    while (bytes_taken < RandItems) begin
      if (!held && bytes_taken >= 200) begin
        // long receiver hold-off while a big code section keeps coming
        held = 1'b1;
        hold_off_req = 1'b1;
        start_of_file = 1'b1;
        put_code(HdrCode, pick_addr(), 16'd40);
      end
      if (!drained_once && bytes_taken >= 420) begin
        drained_once = 1'b1;
        idle_input();
        while (board.pending() != 0) @(posedge clk_i);
      end
      steady = (bytes_taken >= 280 && bytes_taken < 380);
      send_file();
    end
    steady = 1'b0;

    idle_input();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    board.check_drained();
    if (board.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
